FILE: hw/rtl/erav_pkg.sv
// ----------------------------------------------------------------------------
// erav_pkg
// Shared constants, type codes, opcodes and the sample scaling function for
// the element-wise running average unit.
// ----------------------------------------------------------------------------
package erav_pkg;

   // Fixed-point average format
   localparam int DATA_W    = 64;
   localparam int FRAC_BITS = 16;
   localparam int IP_W      = DATA_W - FRAC_BITS;

   // Vector storage
   localparam int ELEMENTS = 256;
   localparam int ADDR_W   = $clog2(ELEMENTS);

   // Field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 8;
   localparam int SAMPLE_W = 32;
   localparam int COUNT_W  = 16;
   localparam int TYPE_W   = 3;

   // Divider
   localparam int DIV_STEPS = DATA_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Opcodes
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
   localparam logic [OP_W-1:0] OP_INC   = 2'd1;
   localparam logic [OP_W-1:0] OP_ACC   = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   // Sample type codes
   localparam logic [TYPE_W-1:0] TYPE_S8  = 3'd0;
   localparam logic [TYPE_W-1:0] TYPE_S16 = 3'd1;
   localparam logic [TYPE_W-1:0] TYPE_S32 = 3'd2;
   localparam logic [TYPE_W-1:0] TYPE_U8  = 3'd3;
   localparam logic [TYPE_W-1:0] TYPE_U16 = 3'd4;
   localparam logic [TYPE_W-1:0] TYPE_U32 = 3'd5;
   localparam logic [TYPE_W-1:0] TYPE_RESET = TYPE_S32;

   // Saturation limits of the average word
   localparam logic [DATA_W-1:0] AVG_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] AVG_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // Scale a raw sample to the fixed-point format (exact, before division)
   function automatic logic [DATA_W-1:0] scale_sample(input logic [SAMPLE_W-1:0] raw,
                                                      input logic [TYPE_W-1:0] t);
      logic [DATA_W-1:0] v;
      case (t)
         TYPE_S8:  v = {{(DATA_W-8){raw[7]}}, raw[7:0]};
         TYPE_S16: v = {{(DATA_W-16){raw[15]}}, raw[15:0]};
         TYPE_S32: v = {{(DATA_W-32){raw[31]}}, raw[31:0]};
         TYPE_U8:  v = {{(DATA_W-8){1'b0}}, raw[7:0]};
         TYPE_U16: v = {{(DATA_W-16){1'b0}}, raw[15:0]};
         TYPE_U32: v = {{(DATA_W-32){1'b0}}, raw[31:0]};
         default:  v = '0;
      endcase
      return v << FRAC_BITS;
   endfunction

endpackage

FILE: hw/rtl/erav_ram.sv
// ----------------------------------------------------------------------------
// erav_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module erav_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/erav_div.sv
// ----------------------------------------------------------------------------
// erav_div
// Radix-2 restoring divider: unsigned 64-bit dividend by 16-bit divisor,
// one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module erav_div
   import erav_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DATA_W-1:0]  dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [DATA_W-1:0]  quotient
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DATA_W-1:0]  quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] dvs_ff, dvs_in;
   logic [COUNT_W:0]   trial;
   logic               fits;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[DATA_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DATA_W-2:0], fits};
         rem_in  = fits ? COUNT_W'(trial - {1'b0, dvs_ff}) : trial[COUNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   property p_done_ends_busy;
      @(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff;
   endproperty
   a_done_ends_busy: assert property (p_done_ends_busy)
      else $error("divider done while still busy");

   property p_last_step_done;
      @(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == STEP_W'(DIV_STEPS - 1)) |=> done_ff;
   endproperty
   a_last_step_done: assert property (p_last_step_done)
      else $error("divider missed done after last step");

   property p_idle_quiet;
      @(posedge clock) disable iff (reset)
      (!busy_ff && !start) |=> !busy_ff;
   endproperty
   a_idle_quiet: assert property (p_idle_quiet)
      else $error("divider started without start");

endmodule

FILE: hw/rtl/erav_cast.sv
// ----------------------------------------------------------------------------
// erav_cast
// Readout cast: integer part of a fixed-point average, truncated toward zero
// and saturated to the configured sample type, with a clip flag.
// ----------------------------------------------------------------------------
module erav_cast
   import erav_pkg::*;
(
   input  logic [DATA_W-1:0]   avg,
   input  logic [TYPE_W-1:0]   elem_type,
   output logic [SAMPLE_W-1:0] typed,
   output logic                saturated
);

   logic              neg;
   logic [DATA_W-1:0] mag;
   logic [IP_W-1:0]   ip;
   logic [IP_W-1:0]   lim;
   logic [IP_W-1:0]   neg_lim;
   logic [IP_W-1:0]   mask;
   logic [IP_W-1:0]   half;
   logic              is_signed;
   logic              known;

   // Decode type range
   always_comb begin
      known     = 1'b1;
      is_signed = 1'b0;
      mask      = '0;
      case (elem_type)
         TYPE_S8:  begin is_signed = 1'b1; mask = IP_W'(8'hFF); end
         TYPE_S16: begin is_signed = 1'b1; mask = IP_W'(16'hFFFF); end
         TYPE_S32: begin is_signed = 1'b1; mask = IP_W'(32'hFFFF_FFFF); end
         TYPE_U8:  mask = IP_W'(8'hFF);
         TYPE_U16: mask = IP_W'(16'hFFFF);
         TYPE_U32: mask = IP_W'(32'hFFFF_FFFF);
         default:  known = 1'b0;
      endcase
      half = (mask >> 1) + IP_W'(1);
   end

   // Truncate and clip
   always_comb begin
      neg       = avg[DATA_W-1];
      mag       = neg ? (~avg + DATA_W'(1)) : avg;
      ip        = mag[DATA_W-1:FRAC_BITS];
      lim       = ip;
      saturated = 1'b0;
      typed     = '0;
      if (known) begin
         if (is_signed) begin
            if (neg) begin
               if (ip > half) begin
                  lim       = half;
                  saturated = 1'b1;
               end
            end else if (ip > half - IP_W'(1)) begin
               lim       = half - IP_W'(1);
               saturated = 1'b1;
            end
         end else begin
            if (neg) begin
               lim       = '0;
               saturated = ip != '0;
            end else if (ip > mask) begin
               lim       = mask;
               saturated = 1'b1;
            end
         end
      end else begin
         lim = '0;
      end
      neg_lim = ~lim + IP_W'(1);
      typed   = (neg && is_signed) ? neg_lim[SAMPLE_W-1:0] & mask[SAMPLE_W-1:0]
                                   : lim[SAMPLE_W-1:0] & mask[SAMPLE_W-1:0];
   end

endmodule

FILE: hw/rtl/elementwise_running_average.sv
// ----------------------------------------------------------------------------
// elementwise_running_average
// Per-element cumulative moving average over a 256-entry store of signed
// Q47.16 words, with clear, incremental update, accumulate and typed readout.
// ----------------------------------------------------------------------------
// One word is handled at a time. Clear and readout pass from accept to result
// through store read, result register and back to idle; incremental update
// and accumulate also pass through the radix-2 divider, which produces one
// quotient bit per cycle over the 64-bit dividend. The store is a synchronous
// RAM read once and written once per word; a valid bit per entry makes every
// entry read as zero after reset without a clearing pass. A finished result
// sits in the output register, and the next word is taken while it waits.
// ----------------------------------------------------------------------------
module elementwise_running_average
   import erav_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // Configuration
   input  logic                csr_wr_en,
   input  logic [TYPE_W-1:0]   csr_wr_data,
   // Request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_opcode,
   input  logic [INDEX_W-1:0]  req_element_index,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  logic [COUNT_W-1:0]  req_count,
   // Response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_index_out,
   output logic [DATA_W-1:0]   rsp_average,
   output logic [SAMPLE_W-1:0] rsp_typed_value,
   output logic                rsp_saturated
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [ELEMENTS-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [OP_W-1:0]     op_ff, op_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                hit_ff, hit_in;
   logic                in_range_ff, in_range_in;
   logic                sub_ff, sub_in;
   logic [DATA_W-1:0]   avg_ff, avg_in;

   logic [INDEX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [DATA_W-1:0]   rsp_average_ff, rsp_average_in;
   logic [SAMPLE_W-1:0] rsp_typed_ff, rsp_typed_in;
   logic                rsp_sat_ff, rsp_sat_in;

   logic                accept;
   logic                slot_free;
   logic                finish;
   logic                type_ok;
   logic [DATA_W-1:0]   ram_rd_data;
   logic [DATA_W-1:0]   avg_rd;
   logic [DATA_W-1:0]   x_scaled;
   logic                x_ge;
   logic [DATA_W-1:0]   inc_mag;
   logic [DATA_W-1:0]   acc_mag;
   logic                div_start;
   logic                div_done;
   logic [DATA_W-1:0]   div_quo;
   logic [DATA_W-1:0]   sum;
   logic                ovf;
   logic [SAMPLE_W-1:0] cast_typed;
   logic                cast_sat;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_DONE) && slot_free;
   assign type_ok   = type_ff <= TYPE_U32;

   // Element store
   erav_ram #(
      .WIDTH (DATA_W),
      .DEPTH (ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (finish && in_range_ff),
      .wr_addr (idx_ff[ADDR_W-1:0]),
      .wr_data (avg_ff),
      .rd_en   (accept),
      .rd_addr (req_element_index[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // Read stage: scale sample, form the dividend magnitude
   always_comb begin
      avg_rd    = hit_ff ? ram_rd_data : '0;
      x_scaled  = scale_sample(sample_ff, type_ff);
      x_ge      = $signed(x_scaled) >= $signed(avg_rd);
      inc_mag   = x_ge ? (x_scaled - avg_rd) : (avg_rd - x_scaled);
      acc_mag   = x_scaled[DATA_W-1] ? (~x_scaled + DATA_W'(1)) : x_scaled;
      div_start = (state_ff == ST_READ) && in_range_ff && type_ok &&
                  (op_ff == OP_INC || op_ff == OP_ACC);
   end

   erav_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((op_ff == OP_ACC) ? acc_mag : inc_mag),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Apply the quotient, clip accumulate overflow
   always_comb begin
      sum = sub_ff ? (avg_ff - div_quo) : (avg_ff + div_quo);
      ovf = sub_ff ? (avg_ff[DATA_W-1] && !sum[DATA_W-1])
                   : (!avg_ff[DATA_W-1] && sum[DATA_W-1]);
   end

   erav_cast u_cast (
      .avg       (avg_ff),
      .elem_type (type_ff),
      .typed     (cast_typed),
      .saturated (cast_sat)
   );

   // Sequencer and next values
   always_comb begin
      state_in       = state_ff;
      type_in        = csr_wr_en ? csr_wr_data : type_ff;
      valid_in       = valid_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      op_in          = op_ff;
      idx_in         = idx_ff;
      sample_in      = sample_ff;
      count_in       = count_ff;
      hit_in         = hit_ff;
      in_range_in    = in_range_ff;
      sub_in         = sub_ff;
      avg_in         = avg_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_average_in = rsp_average_ff;
      rsp_typed_in   = rsp_typed_ff;
      rsp_sat_in     = rsp_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_opcode;
               idx_in      = req_element_index;
               sample_in   = req_sample;
               count_in    = (req_count == '0) ? COUNT_W'(1) : req_count;
               hit_in      = valid_ff[req_element_index[ADDR_W-1:0]];
               in_range_in = 32'(req_element_index) < ELEMENTS;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            sub_in = (op_ff == OP_ACC) ? x_scaled[DATA_W-1] : !x_ge;
            if (!in_range_ff || op_ff == OP_CLEAR) begin
               avg_in = '0;
            end else begin
               avg_in = avg_rd;
            end
            state_in = div_start ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            if (div_done) begin
               avg_in   = ovf ? (avg_ff[DATA_W-1] ? AVG_MIN : AVG_MAX) : sum;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               if (in_range_ff) begin
                  valid_in[idx_ff[ADDR_W-1:0]] = 1'b1;
               end
               rsp_valid_in   = 1'b1;
               rsp_index_in   = idx_ff;
               rsp_average_in = avg_ff;
               if (op_ff == OP_READ && in_range_ff) begin
                  rsp_typed_in = cast_typed;
                  rsp_sat_in   = cast_sat;
               end else begin
                  rsp_typed_in = '0;
                  rsp_sat_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         type_ff      <= TYPE_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         type_ff      <= type_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      idx_ff         <= idx_in;
      sample_ff      <= sample_in;
      count_ff       <= count_in;
      hit_ff         <= hit_in;
      in_range_ff    <= in_range_in;
      sub_ff         <= sub_in;
      avg_ff         <= avg_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_average_ff <= rsp_average_in;
      rsp_typed_ff   <= rsp_typed_in;
      rsp_sat_ff     <= rsp_sat_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index_out   = rsp_index_ff;
   assign rsp_average     = rsp_average_ff;
   assign rsp_typed_value = rsp_typed_ff;
   assign rsp_saturated   = rsp_sat_ff;

   property p_div_done_in_div;
      @(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV;
   endproperty
   a_div_done_in_div: assert property (p_div_done_in_div)
      else $error("divider finished outside the divide state");

   property p_finish_loads_rsp;
      @(posedge clock) disable iff (reset)
      finish |=> rsp_valid_ff && state_ff == ST_IDLE;
   endproperty
   a_finish_loads_rsp: assert property (p_finish_loads_rsp)
      else $error("finished word not presented");

   property p_clear_zero;
      @(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && op_ff == OP_CLEAR) |-> avg_ff == '0;
   endproperty
   a_clear_zero: assert property (p_clear_zero)
      else $error("clear left a nonzero average");

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the element-wise running average unit. A directed
// table covers the type extremes, every opcode, zero count, readout clipping
// and an unassigned type code. Random phases then cycle through the sample
// types under shifting backpressure. Every result word is compared field by
// field against the directed table or an in-bench shadow of the average store.
// ----------------------------------------------------------------------------
module tb_top;
   import erav_pkg::*;

   // Unassigned type codes: updates are ignored, readout gives zero
   localparam logic [TYPE_W-1:0] TYPE_SPARE_LO = 3'd6;
   localparam logic [TYPE_W-1:0] TYPE_SPARE_HI = 3'd7;

   localparam int RESULT_LATENCY  = 68;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 58;
   localparam int DIRECTED_ROWS   = 33;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [DATA_W-1:0]   average;
      logic [SAMPLE_W-1:0] typed;
      logic                saturated;
   } avg_result_type;

   typedef enum logic {ROW_WORD, ROW_TYPE} row_kind_type;

   // One directed step: either a request word or a type register write
   typedef struct packed {
      row_kind_type        kind;
      logic [TYPE_W-1:0]   elem_type;
      logic [OP_W-1:0]     op;
      logic [INDEX_W-1:0]  index;
      logic [SAMPLE_W-1:0] sample;
      logic [COUNT_W-1:0]  count;
      logic                known;
      logic [DATA_W-1:0]   average;
      logic [SAMPLE_W-1:0] typed;
      logic                saturated;
   } stim_row_type;

   // Word rows leave elem_type at '0; type rows use only kind and elem_type
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ROW_WORD, '0, OP_READ,  8'd0,   32'h0000_0000, 16'd1,    1'b1,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd0,   32'd100,       16'd1,    1'b1,
        64'h0000_0000_0064_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd0,   32'h0000_0000, 16'd1,    1'b1,
        64'h0000_0000_0064_0000, 32'd100, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd0,   32'd200,       16'd2,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_ACC,   8'd1,   32'h7FFF_FFFF, 16'd0,    1'b1,
        64'h0000_7FFF_FFFF_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd1,   32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        64'h0000_7FFF_FFFF_0000, 32'h7FFF_FFFF, 1'b0},
      '{ROW_WORD, '0, OP_CLEAR, 8'd1,   32'hFFFF_FFFF, 16'hFFFF, 1'b1,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd2,   32'h8000_0000, 16'd1,    1'b1,
        64'hFFFF_8000_0000_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd2,   32'h0000_0000, 16'd1,    1'b1,
        64'hFFFF_8000_0000_0000, 32'h8000_0000, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd2,   32'hFFFF_FFFF, 16'hFFFF, 1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_ACC,   8'd3,   32'hFFFF_FFFF, 16'd3,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd3,   32'h0000_0000, 16'd1,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_TYPE, TYPE_U8, '0, 8'd0, 32'h0, 16'd0, 1'b0, 64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd3,   32'h0000_0000, 16'd1,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd2,   32'h0000_0000, 16'd1,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd4,   32'hFFFF_FFFF, 16'd1,    1'b1,
        64'h0000_0000_00FF_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd4,   32'h0000_0000, 16'd1,    1'b1,
        64'h0000_0000_00FF_0000, 32'h0000_00FF, 1'b0},
      '{ROW_TYPE, TYPE_S8, '0, 8'd0, 32'h0, 16'd0, 1'b0, 64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd4,   32'h0000_0000, 16'd1,    1'b1,
        64'h0000_0000_00FF_0000, 32'h0000_007F, 1'b1},
      '{ROW_WORD, '0, OP_INC,   8'd5,   32'hFFFF_FF80, 16'd1,    1'b1,
        64'hFFFF_FFFF_FF80_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd5,   32'h0000_0000, 16'd1,    1'b1,
        64'hFFFF_FFFF_FF80_0000, 32'h0000_0080, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd2,   32'h0000_0000, 16'd1,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_TYPE, TYPE_SPARE_HI, '0, 8'd0, 32'h0, 16'd0, 1'b0, 64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd4,   32'd5,         16'd1,    1'b1,
        64'h0000_0000_00FF_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_ACC,   8'd4,   32'd5,         16'd1,    1'b1,
        64'h0000_0000_00FF_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd4,   32'h0000_0000, 16'd1,    1'b1,
        64'h0000_0000_00FF_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_CLEAR, 8'd4,   32'h0000_0000, 16'd1,    1'b1,
        64'h0, 32'h0, 1'b0},
      '{ROW_TYPE, TYPE_U32, '0, 8'd0, 32'h0, 16'd0, 1'b0, 64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_ACC,   8'd255, 32'hFFFF_FFFF, 16'hFFFF, 1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd255, 32'h0000_0000, 16'd1,    1'b0,
        64'h0, 32'h0, 1'b0},
      '{ROW_TYPE, TYPE_S16, '0, 8'd0, 32'h0, 16'd0, 1'b0, 64'h0, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_INC,   8'd6,   32'h0001_8000, 16'd1,    1'b1,
        64'hFFFF_FFFF_8000_0000, 32'h0, 1'b0},
      '{ROW_WORD, '0, OP_READ,  8'd6,   32'h0000_0000, 16'd1,    1'b1,
        64'hFFFF_FFFF_8000_0000, 32'h0000_8000, 1'b0}
   };

   // Type schedule of the random phases; four phases per backpressure mode
   localparam logic [TYPE_W-1:0] PHASE_TYPES [PHASES] = '{
      TYPE_S8, TYPE_U16, TYPE_S32, TYPE_U8,
      TYPE_S16, TYPE_U32, TYPE_SPARE_HI, TYPE_S8,
      TYPE_U32, TYPE_SPARE_LO, TYPE_S16, TYPE_U8
   };

   localparam logic [SAMPLE_W-1:0] EDGE_SAMPLES [10] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_007F,
      32'h0000_0080, 32'h0000_00FF, 32'h0000_7FFF, 32'h0000_8000, 32'h0000_FFFF
   };

   logic                clock;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [TYPE_W-1:0]   csr_wr_data = TYPE_RESET;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode = OP_CLEAR;
   logic [INDEX_W-1:0]  req_element_index = '0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic [COUNT_W-1:0]  req_count = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_index_out;
   logic [DATA_W-1:0]   rsp_average;
   logic [SAMPLE_W-1:0] rsp_typed_value;
   logic                rsp_saturated;

   // Shadow state of the unit
   logic [DATA_W-1:0]   shadow_averages [ELEMENTS];
   logic [TYPE_W-1:0]   shadow_type = TYPE_RESET;
   avg_result_type      pending_results [$];

   int                  send_idle_pct = 12;
   int                  recv_idle_pct = 75;
   int                  words_sent = 0;
   int                  mismatches = 0;
   int                  cycle_count = 0;

   elementwise_running_average dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_element_index (req_element_index),
      .req_sample        (req_sample),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_index_out     (rsp_index_out),
      .rsp_average       (rsp_average),
      .rsp_typed_value   (rsp_typed_value),
      .rsp_saturated     (rsp_saturated)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      foreach (shadow_averages[i]) shadow_averages[i] = '0;
   end

   function automatic int unsigned type_bits(input logic [TYPE_W-1:0] t);
      case (t)
         TYPE_S8, TYPE_U8:   return 8;
         TYPE_S16, TYPE_U16: return 16;
         default:            return 32;
      endcase
   endfunction

   // Widen the sample to the element type, then move it into Q47.16
   function automatic logic [DATA_W-1:0] fixed_sample(input logic [SAMPLE_W-1:0] smp,
                                                      input logic [TYPE_W-1:0] t);
      logic signed [DATA_W-1:0] v;
      case (t)
         TYPE_S8:  v = DATA_W'($signed(smp[7:0]));
         TYPE_S16: v = DATA_W'($signed(smp[15:0]));
         TYPE_S32: v = DATA_W'($signed(smp));
         TYPE_U8:  v = DATA_W'(smp[7:0]);
         TYPE_U16: v = DATA_W'(smp[15:0]);
         default:  v = DATA_W'(smp);
      endcase
      return v <<< FRAC_BITS;
   endfunction

   // Apply one word to the shadow store and return the result word it gives
   function automatic avg_result_type predict_word(input logic [OP_W-1:0] op,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [SAMPLE_W-1:0] smp,
                                                   input logic [COUNT_W-1:0] cnt);
      avg_result_type           r;
      logic [DATA_W-1:0]        avg, x, divisor, total, mag, whole, limit, field_mask;
      logic signed [DATA_W-1:0] share;
      int unsigned              w;
      bit                       known_type;
      divisor    = (cnt == '0) ? 64'd1 : {{(DATA_W-COUNT_W){1'b0}}, cnt};
      known_type = (shadow_type <= TYPE_U32);
      avg        = shadow_averages[idx];
      r          = '0;
      r.index    = idx;
      case (op)
         OP_CLEAR: avg = '0;
         OP_INC: if (known_type) begin
            // result lies between old average and sample, so no overflow
            x = fixed_sample(smp, shadow_type);
            if ($signed(x) >= $signed(avg)) avg = avg + (x - avg) / divisor;
            else avg = avg - (avg - x) / divisor;
         end
         OP_ACC: if (known_type) begin
            share = $signed(fixed_sample(smp, shadow_type)) / $signed(divisor);
            total = avg + share;
            // clamp on signed overflow of the sum
            if (avg[DATA_W-1] == share[DATA_W-1] && total[DATA_W-1] != avg[DATA_W-1])
               total = avg[DATA_W-1] ? AVG_MIN : AVG_MAX;
            avg = total;
         end
         default: if (known_type) begin
            w          = type_bits(shadow_type);
            field_mask = (64'd1 << w) - 64'd1;
            mag        = avg[DATA_W-1] ? -avg : avg;
            whole      = mag >> FRAC_BITS;
            if (shadow_type <= TYPE_S32) begin
               limit = 64'd1 << (w - 1);
               if (!avg[DATA_W-1]) limit = limit - 64'd1;
               if (whole > limit) begin
                  whole       = limit;
                  r.saturated = 1'b1;
               end
               r.typed = SAMPLE_W'((avg[DATA_W-1] ? -whole : whole) & field_mask);
            end else if (avg[DATA_W-1]) begin
               // fractions in (-1, 0) read zero without a flag
               r.saturated = (whole != '0);
            end else begin
               if (whole > field_mask) begin
                  whole       = field_mask;
                  r.saturated = 1'b1;
               end
               r.typed = SAMPLE_W'(whole);
            end
         end
      endcase
      shadow_averages[idx] = avg;
      r.average            = avg;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      $display("cycle %0d: %s mismatch, expected %h, got %h", cycle_count, what, want, got);
      mismatches++;
   endtask

   // Offer one word, hold it until accepted, then queue its expected result
   task automatic put_word(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [SAMPLE_W-1:0] smp, input logic [COUNT_W-1:0] cnt,
                           input bit given, input avg_result_type given_result);
      avg_result_type want;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_element_index <= idx;
      req_sample        <= smp;
      req_count         <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = predict_word(op, idx, smp, cnt);
      if (given) want = given_result;
      pending_results.push_back(want);
      words_sent++;
   endtask

   // Drop valid and wait until every expected word has come back
   task automatic await_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_type(input logic [TYPE_W-1:0] t);
      await_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_type = t;
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      if ($urandom_range(3) == 0) return EDGE_SAMPLES[$urandom_range(9)];
      return $urandom;
   endfunction

   // Clear an element, feed it a run of samples, then read it back
   task automatic run_sequence();
      logic [INDEX_W-1:0] idx;
      int                 len;
      bit                 use_acc;
      idx     = INDEX_W'($urandom_range(255));
      len     = $urandom_range(8, 2);
      use_acc = 1'($urandom_range(1));
      put_word(OP_CLEAR, idx, $urandom, COUNT_W'($urandom), 1'b0, '0);
      for (int k = 1; k <= len; k++)
         put_word(use_acc ? OP_ACC : OP_INC, idx, pick_sample(),
                  COUNT_W'(use_acc ? len : k), 1'b0, '0);
      put_word(OP_READ, idx, $urandom, COUNT_W'($urandom), 1'b0, '0);
   endtask

   // Unstructured word; small indexes and counts keep revisiting state
   task automatic noise_word();
      logic [INDEX_W-1:0] idx;
      logic [COUNT_W-1:0] cnt;
      idx = $urandom_range(1) ? INDEX_W'($urandom_range(7)) : INDEX_W'($urandom);
      case ($urandom_range(3))
         0:       cnt = '0;
         1:       cnt = COUNT_W'($urandom_range(8, 1));
         default: cnt = COUNT_W'($urandom);
      endcase
      put_word(OP_W'($urandom), idx, pick_sample(), cnt, 1'b0, '0);
   endtask

   // Receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // Check each accepted result word against the oldest expectation
   always @(posedge clock) begin
      avg_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected word, index", 64'd0, 64'(rsp_index_out));
         end else begin
            want = pending_results.pop_front();
            if (rsp_index_out !== want.index)
               note_mismatch("index_out", 64'(want.index), 64'(rsp_index_out));
            if (rsp_average !== want.average)
               note_mismatch("average", want.average, rsp_average);
            if (rsp_typed_value !== want.typed)
               note_mismatch("typed_value", 64'(want.typed), 64'(rsp_typed_value));
            if (rsp_saturated !== want.saturated)
               note_mismatch("saturated", 64'(want.saturated), 64'(rsp_saturated));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout with %0d words outstanding", pending_results.size());
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      avg_result_type given;
      bit             paused;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_TYPE) begin
            set_type(DIRECTED[i].elem_type);
         end else begin
            given = '{DIRECTED[i].index, DIRECTED[i].average, DIRECTED[i].typed,
                      DIRECTED[i].saturated};
            put_word(DIRECTED[i].op, DIRECTED[i].index, DIRECTED[i].sample,
                     DIRECTED[i].count, DIRECTED[i].known, given);
         end
      end

      // Random phases: sender light / receiver heavy, then swapped, then none
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 4)
            0: begin
               send_idle_pct = 12;
               recv_idle_pct = 75;
            end
            1: begin
               send_idle_pct = 75;
               recv_idle_pct = 12;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         set_type(PHASE_TYPES[phase]);
         words_sent = 0;
         paused     = 1'b0;
         while (words_sent < WORDS_PER_PHASE) begin
            // hold off mid-phase until the unit has drained
            if (phase % 4 == 1 && !paused && words_sent >= WORDS_PER_PHASE / 2) begin
               await_idle();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 65) run_sequence();
            else noise_word();
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (RESULT_LATENCY + 32) @(posedge clock);
      if (mismatches == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
